// ===== rtl/core/cbc_pkg.sv =====
// ----------------------------------------------------------------------------
// cbc_pkg
// shared widths, types and codes for the circle and box contact pipeline
// ----------------------------------------------------------------------------
package cbc_pkg;

   localparam int NORMAL_FRAC_BITS = 14;

   localparam int COORD_W  = 24;
   localparam int EXT_W    = 23;
   localparam int MAG_W    = 23;
   localparam int EDGE_W   = 26;
   localparam int DEPTH_W  = 24;
   localparam int NORMAL_W = 16;
   localparam int NSQ_W    = 2 * MAG_W;
   localparam int ROOT_W   = MAG_W;
   localparam int SQ_STEPS = ROOT_W;
   localparam int REM_W    = ROOT_W + 2;
   localparam int DREM_W   = MAG_W + 1;
   localparam int NEXT_W   = 32;

   localparam logic [1:0] EDGE_LEFT   = 2'd0;
   localparam logic [1:0] EDGE_RIGHT  = 2'd1;
   localparam logic [1:0] EDGE_TOP    = 2'd2;
   localparam logic [1:0] EDGE_BOTTOM = 2'd3;

   typedef struct packed {
      logic               hit;
      logic               on_box;
      logic [1:0]         edge_sel;
      logic               dx_neg;
      logic               dy_neg;
      logic [MAG_W-1:0]   dx_mag;
      logic [MAG_W-1:0]   dy_mag;
      logic [EXT_W-1:0]   radius;
      logic [DEPTH_W-1:0] depth_in;
   } cbc_ctx_type;

   typedef struct packed {
      logic              valid;
      logic [NSQ_W-1:0]  n;
      logic [ROOT_W-1:0] root;
      logic [REM_W-1:0]  rem;
      cbc_ctx_type       ctx;
   } cbc_sq_type;

   typedef struct packed {
      logic              valid;
      logic [ROOT_W-1:0] span;
      logic [DREM_W-1:0] rem_x;
      logic [DREM_W-1:0] rem_y;
      cbc_ctx_type       ctx;
   } cbc_dv_type;

endpackage

// ===== rtl/core/cbc_intf.sv =====
// ----------------------------------------------------------------------------
// cbc channel interfaces
// query and contact result channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface cbc_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [cbc_pkg::COORD_W-1:0]  box_left;
   logic signed [cbc_pkg::COORD_W-1:0]  box_top;
   logic        [cbc_pkg::EXT_W-1:0]    box_width;
   logic        [cbc_pkg::EXT_W-1:0]    box_height;
   logic signed [cbc_pkg::COORD_W-1:0]  center_x;
   logic signed [cbc_pkg::COORD_W-1:0]  center_y;
   logic        [cbc_pkg::EXT_W-1:0]    circle_radius;

   modport source (output valid, box_left, box_top, box_width, box_height,
                   center_x, center_y, circle_radius, input ready);
   modport sink (input valid, box_left, box_top, box_width, box_height,
                 center_x, center_y, circle_radius, output ready);
endinterface

interface cbc_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                hit;
   logic        [cbc_pkg::DEPTH_W-1:0]  depth;
   logic signed [cbc_pkg::NORMAL_W-1:0] normal_x;
   logic signed [cbc_pkg::NORMAL_W-1:0] normal_y;

   modport source (output valid, hit, depth, normal_x, normal_y, input ready);
   modport sink (input valid, hit, depth, normal_x, normal_y, output ready);
endinterface

// ===== rtl/core/cbc_front.sv =====
// ----------------------------------------------------------------------------
// cbc_front
// clamp, squares, hit compare and nearest edge pick, three register stages
// ----------------------------------------------------------------------------
module cbc_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   cbc_req_if.sink             req,
   output cbc_pkg::cbc_sq_type sq_o
);

   // stage a
   logic signed [cbc_pkg::EDGE_W-1:0] left, top, right, bottom, cx, cy;
   logic signed [cbc_pkg::EDGE_W-1:0] clx, cly, dx, dy;
   logic                               a_valid_ff;
   logic        [cbc_pkg::MAG_W:0]     a_dxm_ff, a_dym_ff;
   logic                               a_dxn_ff, a_dyn_ff;
   logic        [cbc_pkg::EXT_W-1:0]   a_r_ff;
   logic signed [cbc_pkg::EDGE_W-1:0]  a_el_ff, a_er_ff, a_et_ff, a_eb_ff;

   assign req.ready = adv;
   assign left   = cbc_pkg::EDGE_W'(req.box_left);
   assign top    = cbc_pkg::EDGE_W'(req.box_top);
   assign cx     = cbc_pkg::EDGE_W'(req.center_x);
   assign cy     = cbc_pkg::EDGE_W'(req.center_y);
   assign right  = left + $signed({3'b000, req.box_width});
   assign bottom = top + $signed({3'b000, req.box_height});

   always_comb begin
      if (cx < left) begin
         clx = left;
      end else if (cx > right) begin
         clx = right;
      end else begin
         clx = cx;
      end
      if (cy < top) begin
         cly = top;
      end else if (cy > bottom) begin
         cly = bottom;
      end else begin
         cly = cy;
      end
      dx = cx - clx;
      dy = cy - cly;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_dxn_ff <= dx[cbc_pkg::EDGE_W-1];
         a_dyn_ff <= dy[cbc_pkg::EDGE_W-1];
         a_dxm_ff <= dx[cbc_pkg::EDGE_W-1] ? 24'(-dx) : 24'(dx);
         a_dym_ff <= dy[cbc_pkg::EDGE_W-1] ? 24'(-dy) : 24'(dy);
         a_r_ff   <= req.circle_radius;
         a_el_ff  <= cx - left;
         a_er_ff  <= right - cx;
         a_et_ff  <= cy - top;
         a_eb_ff  <= bottom - cy;
      end
   end

   // stage b
   logic                               b_valid_ff;
   logic [2*(cbc_pkg::MAG_W+1)-1:0]    b_dxsq_ff, b_dysq_ff;
   logic [2*cbc_pkg::EXT_W-1:0]        b_rsq_ff;
   logic [cbc_pkg::MAG_W-1:0]          b_dxm_ff, b_dym_ff;
   logic                               b_dxn_ff, b_dyn_ff;
   logic [cbc_pkg::EXT_W-1:0]          b_r_ff;
   logic [cbc_pkg::EDGE_W-1:0]         b_best_ff;
   logic [1:0]                         b_edge_ff;
   logic signed [cbc_pkg::EDGE_W-1:0]  best;
   logic [1:0]                         best_edge;

   always_comb begin
      best = a_el_ff;
      best_edge = cbc_pkg::EDGE_LEFT;
      if (a_er_ff < best) begin
         best = a_er_ff;
         best_edge = cbc_pkg::EDGE_RIGHT;
      end
      if (a_et_ff < best) begin
         best = a_et_ff;
         best_edge = cbc_pkg::EDGE_TOP;
      end
      if (a_eb_ff < best) begin
         best = a_eb_ff;
         best_edge = cbc_pkg::EDGE_BOTTOM;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (adv) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b_dxsq_ff <= a_dxm_ff * a_dxm_ff;
         b_dysq_ff <= a_dym_ff * a_dym_ff;
         b_rsq_ff  <= a_r_ff * a_r_ff;
         b_dxm_ff  <= a_dxm_ff[cbc_pkg::MAG_W-1:0];
         b_dym_ff  <= a_dym_ff[cbc_pkg::MAG_W-1:0];
         b_dxn_ff  <= a_dxn_ff;
         b_dyn_ff  <= a_dyn_ff;
         b_r_ff    <= a_r_ff;
         b_best_ff <= best[cbc_pkg::EDGE_W-1] ? '0 : best;
         b_edge_ff <= best_edge;
      end
   end

   // stage c
   logic [2*(cbc_pkg::MAG_W+1):0] dsq;
   logic [cbc_pkg::EDGE_W:0]      din_sum;
   cbc_pkg::cbc_sq_type           c_ff;

   assign dsq     = {1'b0, b_dxsq_ff} + {1'b0, b_dysq_ff};
   assign din_sum = {1'b0, b_best_ff} + (cbc_pkg::EDGE_W+1)'(b_r_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         c_ff.valid <= 1'b0;
      end else if (adv) begin
         c_ff.valid <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c_ff.n            <= dsq[cbc_pkg::NSQ_W-1:0];
         c_ff.root         <= '0;
         c_ff.rem          <= '0;
         c_ff.ctx.hit      <= dsq <= (2*(cbc_pkg::MAG_W+1)+1)'(b_rsq_ff);
         c_ff.ctx.on_box   <= dsq == '0;
         c_ff.ctx.edge_sel <= b_edge_ff;
         c_ff.ctx.dx_neg   <= b_dxn_ff;
         c_ff.ctx.dy_neg   <= b_dyn_ff;
         c_ff.ctx.dx_mag   <= b_dxm_ff;
         c_ff.ctx.dy_mag   <= b_dym_ff;
         c_ff.ctx.radius   <= b_r_ff;
         c_ff.ctx.depth_in <= (din_sum > (cbc_pkg::EDGE_W+1)'({cbc_pkg::DEPTH_W{1'b1}}))
                              ? {cbc_pkg::DEPTH_W{1'b1}}
                              : din_sum[cbc_pkg::DEPTH_W-1:0];
      end
   end

   assign sq_o = c_ff;

endmodule

// ===== rtl/core/cbc_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// cbc_sqrt_cell
// one root bit of the integer square root, two radicand bits per cell
// ----------------------------------------------------------------------------
module cbc_sqrt_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  cbc_pkg::cbc_sq_type sq_i,
   output cbc_pkg::cbc_sq_type sq_o
);

   localparam int CUR_W = cbc_pkg::REM_W + 2;

   logic [CUR_W-1:0]          cur, trial;
   logic                      take;
   cbc_pkg::cbc_sq_type       sq_ff;

   assign cur   = {sq_i.rem, sq_i.n[cbc_pkg::NSQ_W-1 -: 2]};
   assign trial = CUR_W'({sq_i.root, 2'b01});
   assign take  = cur >= trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_ff.valid <= 1'b0;
      end else if (adv) begin
         sq_ff.valid <= sq_i.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_ff.n    <= {sq_i.n[cbc_pkg::NSQ_W-3:0], 2'b00};
         sq_ff.root <= {sq_i.root[cbc_pkg::ROOT_W-2:0], take};
         sq_ff.rem  <= take ? cbc_pkg::REM_W'(cur - trial) : cbc_pkg::REM_W'(cur);
         sq_ff.ctx  <= sq_i.ctx;
      end
   end

   assign sq_o = sq_ff;

endmodule

// ===== rtl/core/cbc_div_cell.sv =====
// ----------------------------------------------------------------------------
// cbc_div_cell
// one quotient bit of both normal components, restoring division
// ----------------------------------------------------------------------------
module cbc_div_cell #(
   parameter int QW = cbc_pkg::NORMAL_FRAC_BITS + 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  cbc_pkg::cbc_dv_type dv_i,
   input  logic [QW-1:0]       qx_i,
   input  logic [QW-1:0]       qy_i,
   output cbc_pkg::cbc_dv_type dv_o,
   output logic [QW-1:0]       qx_o,
   output logic [QW-1:0]       qy_o
);

   logic [cbc_pkg::DREM_W-1:0] dist_ext, rx, ry;
   logic                       gx, gy;
   cbc_pkg::cbc_dv_type        dv_ff;
   logic [QW-1:0]              qx_ff, qy_ff;

   assign dist_ext = cbc_pkg::DREM_W'(dv_i.span);
   assign gx = dv_i.rem_x >= dist_ext;
   assign gy = dv_i.rem_y >= dist_ext;
   assign rx = gx ? dv_i.rem_x - dist_ext : dv_i.rem_x;
   assign ry = gy ? dv_i.rem_y - dist_ext : dv_i.rem_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff.valid <= 1'b0;
      end else if (adv) begin
         dv_ff.valid <= dv_i.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_ff.span  <= dv_i.span;
         dv_ff.rem_x <= {rx[cbc_pkg::DREM_W-2:0], 1'b0};
         dv_ff.rem_y <= {ry[cbc_pkg::DREM_W-2:0], 1'b0};
         dv_ff.ctx   <= dv_i.ctx;
         qx_ff       <= {qx_i[QW-2:0], gx};
         qy_ff       <= {qy_i[QW-2:0], gy};
      end
   end

   assign dv_o = dv_ff;
   assign qx_o = qx_ff;
   assign qy_o = qy_ff;

endmodule

// ===== rtl/core/circle_box_contact.sv =====
// ----------------------------------------------------------------------------
// circle_box_contact
// circle against axis-aligned box contact test with normal and depth
// ----------------------------------------------------------------------------
// query to result: front stages, sqrt cells, divide cells, then the output register
// throughput: one query per cycle unless stalled, set by sqrt and divide cell rows
// the whole pipeline moves when the output register is empty or being taken
// synchronous reset clears all valid bits; no clearing pass
module circle_box_contact #(
   parameter int NORMAL_FRAC_BITS = cbc_pkg::NORMAL_FRAC_BITS
) (
   input logic       clock,
   input logic       reset,
   cbc_req_if.sink   req_if,
   cbc_rsp_if.source rsp_if
);

   localparam int QW = NORMAL_FRAC_BITS + 1;
   localparam int DS = QW;

   logic adv;
   logic out_valid_ff;

   assign adv = !out_valid_ff || rsp_if.ready;

   cbc_pkg::cbc_sq_type sq_chain [cbc_pkg::SQ_STEPS+1];
   cbc_pkg::cbc_dv_type dv_chain [DS+1];
   logic [QW-1:0]       qx_chain [DS+1];
   logic [QW-1:0]       qy_chain [DS+1];

   cbc_front u_front (
      .clock (clock),
      .reset (reset),
      .adv   (adv),
      .req   (req_if),
      .sq_o  (sq_chain[0])
   );

   for (genvar i = 0; i < cbc_pkg::SQ_STEPS; i++) begin : g_sqrt
      cbc_sqrt_cell u_cell (
         .clock (clock),
         .reset (reset),
         .adv   (adv),
         .sq_i  (sq_chain[i]),
         .sq_o  (sq_chain[i+1])
      );
   end

   always_comb begin
      dv_chain[0].valid = sq_chain[cbc_pkg::SQ_STEPS].valid;
      dv_chain[0].span  = sq_chain[cbc_pkg::SQ_STEPS].root;
      dv_chain[0].rem_x = cbc_pkg::DREM_W'(sq_chain[cbc_pkg::SQ_STEPS].ctx.dx_mag);
      dv_chain[0].rem_y = cbc_pkg::DREM_W'(sq_chain[cbc_pkg::SQ_STEPS].ctx.dy_mag);
      dv_chain[0].ctx   = sq_chain[cbc_pkg::SQ_STEPS].ctx;
   end
   assign qx_chain[0] = '0;
   assign qy_chain[0] = '0;

   for (genvar i = 0; i < DS; i++) begin : g_div
      cbc_div_cell #(.QW(QW)) u_cell (
         .clock (clock),
         .reset (reset),
         .adv   (adv),
         .dv_i  (dv_chain[i]),
         .qx_i  (qx_chain[i]),
         .qy_i  (qy_chain[i]),
         .dv_o  (dv_chain[i+1]),
         .qx_o  (qx_chain[i+1]),
         .qy_o  (qy_chain[i+1])
      );
   end

   // result assembly
   cbc_pkg::cbc_dv_type                 last;
   logic [cbc_pkg::NEXT_W-1:0]          qx_ext, qy_ext, unit;
   logic [cbc_pkg::NEXT_W-1:0]          nx_w, ny_w;
   logic                                hit_in;
   logic [cbc_pkg::DEPTH_W-1:0]         depth_in;
   logic [cbc_pkg::NORMAL_W-1:0]        nx_in, ny_in;
   logic                                hit_ff;
   logic [cbc_pkg::DEPTH_W-1:0]         depth_ff;
   logic [cbc_pkg::NORMAL_W-1:0]        nx_ff, ny_ff;

   assign last   = dv_chain[DS];
   assign qx_ext = cbc_pkg::NEXT_W'(qx_chain[DS]);
   assign qy_ext = cbc_pkg::NEXT_W'(qy_chain[DS]);
   assign unit   = cbc_pkg::NEXT_W'(1) << NORMAL_FRAC_BITS;
   assign nx_w   = last.ctx.dx_neg ? -qx_ext : qx_ext;
   assign ny_w   = last.ctx.dy_neg ? -qy_ext : qy_ext;

   always_comb begin
      hit_in   = last.ctx.hit;
      depth_in = '0;
      nx_in    = '0;
      ny_in    = '0;
      if (last.ctx.hit && !last.ctx.on_box) begin
         depth_in = cbc_pkg::DEPTH_W'(last.ctx.radius - last.span);
         nx_in    = nx_w[cbc_pkg::NORMAL_W-1:0];
         ny_in    = ny_w[cbc_pkg::NORMAL_W-1:0];
      end else if (last.ctx.hit) begin
         depth_in = last.ctx.depth_in;
         unique case (last.ctx.edge_sel)
            cbc_pkg::EDGE_LEFT: begin
               nx_in = cbc_pkg::NORMAL_W'(-unit);
            end
            cbc_pkg::EDGE_RIGHT: begin
               nx_in = unit[cbc_pkg::NORMAL_W-1:0];
            end
            cbc_pkg::EDGE_TOP: begin
               ny_in = cbc_pkg::NORMAL_W'(-unit);
            end
            default: begin
               ny_in = unit[cbc_pkg::NORMAL_W-1:0];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= last.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         hit_ff   <= hit_in;
         depth_ff <= depth_in;
         nx_ff    <= nx_in;
         ny_ff    <= ny_in;
      end
   end

   assign rsp_if.valid    = out_valid_ff;
   assign rsp_if.hit      = hit_ff;
   assign rsp_if.depth    = depth_ff;
   assign rsp_if.normal_x = nx_ff;
   assign rsp_if.normal_y = ny_ff;

   a_miss_clean: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !hit_ff |-> depth_ff == '0 && nx_ff == '0 && ny_ff == '0)
      else $error("miss result carries nonzero fields");

   a_quot_bound: assert property (@(posedge clock) disable iff (reset)
      last.valid && last.ctx.hit && !last.ctx.on_box |->
         qx_ext <= unit && qy_ext <= unit)
      else $error("normal quotient above unit");

   a_dist_bound: assert property (@(posedge clock) disable iff (reset)
      last.valid && last.ctx.hit |-> last.span <= last.ctx.radius)
      else $error("distance above radius on hit");

   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !out_valid_ff |-> req_if.ready)
      else $error("input stalled with empty output register");

endmodule

// ===== tb/sv/tb_circle_box_contact_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_circle_box_contact_if
// testbench-side note: the query and contact channels are the cbc_req_if and
// cbc_rsp_if interfaces of the design; this file holds the result record type
// ----------------------------------------------------------------------------
package tb_cbc_types_pkg;

   typedef struct packed {
      logic               hit;
      logic [23:0]        depth;
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
   } contact_type;

endpackage

// ===== tb/sv/tb_circle_box_contact.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_circle_box_contact
// drives box and circle queries into the contact pipeline, predicts each
// contact result with an integer model and checks results in order
// ----------------------------------------------------------------------------
module tb_circle_box_contact;

   localparam int NFB = cbc_pkg::NORMAL_FRAC_BITS;
   localparam int STALL_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cbc_req_if req_if ();
   cbc_rsp_if rsp_if ();

   circle_box_contact i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if.sink),
      .rsp_if (rsp_if.source)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   tb_cbc_types_pkg::contact_type expected_contacts[$];
   int mismatch_count = 0;
   int result_count = 0;
   int query_count = 0;
   int hit_count = 0;
   int inside_count = 0;
   int idle_cycles = 0;
   bit timed_out = 1'b0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n = n - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic logic [15:0] unit_component(longint d, longint unsigned span);
      longint unsigned mag;
      longint unsigned q;
      mag = (d < 0) ? -d : d;
      q = (mag << NFB) / span;
      if (d < 0) q = -q;
      return q[15:0];
   endfunction

   function automatic logic [15:0] axis_component(int sgn);
      longint unsigned u;
      u = 64'd1 << NFB;
      if (sgn < 0) u = -u;
      return (sgn == 0) ? 16'd0 : u[15:0];
   endfunction

   function automatic tb_cbc_types_pkg::contact_type predict_contact(
      logic [23:0] bl, logic [23:0] bt, logic [22:0] bw, logic [22:0] bh,
      logic [23:0] cxv, logic [23:0] cyv, logic [22:0] rad);
      longint left, top, right, bottom, cx, cy, dx, dy, cl, best;
      longint unsigned dsq, rsq, span, dep, r;
      int nx, ny;
      tb_cbc_types_pkg::contact_type c;
      left = longint'($signed(bl));
      top = longint'($signed(bt));
      cx = longint'($signed(cxv));
      cy = longint'($signed(cyv));
      right = left + longint'(bw);
      bottom = top + longint'(bh);
      r = longint'(rad);
      cl = (cx < right) ? cx : right;
      cl = (left > cl) ? left : cl;
      dx = cx - cl;
      cl = (cy < bottom) ? cy : bottom;
      cl = (top > cl) ? top : cl;
      dy = cy - cl;
      dsq = dx * dx + dy * dy;
      rsq = r * r;
      c = '0;
      if (dsq > rsq) return c;
      c.hit = 1'b1;
      if (dsq > 0) begin
         span = int_sqrt(dsq);
         dep = r - span;
         c.depth = dep[23:0];
         c.normal_x = unit_component(dx, span);
         c.normal_y = unit_component(dy, span);
      end else begin
         best = cx - left; nx = -1; ny = 0;
         if (right - cx < best) begin best = right - cx; nx = 1; ny = 0; end
         if (cy - top < best) begin best = cy - top; nx = 0; ny = -1; end
         if (bottom - cy < best) begin best = bottom - cy; nx = 0; ny = 1; end
         if (best < 0) best = 0;
         dep = r + best;
         c.depth = (dep > 64'd16777215) ? 24'hFFFFFF : dep[23:0];
         c.normal_x = axis_component(nx);
         c.normal_y = axis_component(ny);
      end
      return c;
   endfunction

   task automatic send_query(logic [23:0] bl, logic [23:0] bt, logic [22:0] bw,
                             logic [22:0] bh, logic [23:0] cxv, logic [23:0] cyv,
                             logic [22:0] rad);
      tb_cbc_types_pkg::contact_type c;
      bit idle;
      idle = ($urandom_range(99) < send_idle_pct);
      if (idle) req_if.valid <= 1'b0;
      while (idle) begin
         @(posedge clock);
         idle = ($urandom_range(99) < send_idle_pct);
      end
      c = predict_contact(bl, bt, bw, bh, cxv, cyv, rad);
      req_if.valid <= 1'b1;
      req_if.box_left <= bl;
      req_if.box_top <= bt;
      req_if.box_width <= bw;
      req_if.box_height <= bh;
      req_if.center_x <= cxv;
      req_if.center_y <= cyv;
      req_if.circle_radius <= rad;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      expected_contacts.insert(expected_contacts.size(), c);
      query_count++;
      if (c.hit) hit_count++;
      if (c.hit && c.depth >= rad && (c.normal_x == 0 || c.normal_y == 0)) inside_count++;
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (expected_contacts.size() != 0 && !timed_out) @(posedge clock);
   endtask

   always @(posedge clock) begin
      tb_cbc_types_pkg::contact_type exp_c;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         result_count++;
         if (expected_contacts.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected result at %0t", $realtime);
         end else begin
            exp_c = expected_contacts.pop_front();
            if (exp_c.hit !== rsp_if.hit || exp_c.depth !== rsp_if.depth ||
                exp_c.normal_x !== rsp_if.normal_x || exp_c.normal_y !== rsp_if.normal_y) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"mismatch: exp hit=%0d depth=%0d nx=%0d ny=%0d, ",
                            "got hit=%0d depth=%0d nx=%0d ny=%0d"},
                           exp_c.hit, exp_c.depth, exp_c.normal_x, exp_c.normal_y,
                           rsp_if.hit, rsp_if.depth, rsp_if.normal_x, rsp_if.normal_y);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (idle_cycles >= STALL_LIMIT) begin
            timed_out = 1'b1;
            $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   function automatic logic [23:0] rand_coord();
      case ($urandom_range(3))
         0: return 24'($urandom);
         1: return 24'($signed($urandom_range(4000)) - 2000);
         2: return $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
         default: return 24'($signed($urandom_range(200000)) - 100000);
      endcase
   endfunction

   function automatic logic [22:0] rand_ext();
      case ($urandom_range(3))
         0: return 23'($urandom);
         1: return 23'($urandom_range(3000));
         2: return $urandom_range(1) ? 23'h7FFFFF : 23'h0;
         default: return 23'($urandom_range(100000));
      endcase
   endfunction

   task automatic test_directed();
      send_query(24'h0, 24'h0, 23'd0, 23'd0, 24'h0, 24'h0, 23'd0);
      send_query(24'h0, 24'h0, 23'd1000, 23'd1000, 24'd500, 24'd500, 23'd10);
      send_query(24'h0, 24'h0, 23'd1000, 23'd1000, 24'd100, 24'd500, 23'd10);
      send_query(24'h0, 24'h0, 23'd1000, 23'd1000, 24'd900, 24'd500, 23'd10);
      send_query(24'h0, 24'h0, 23'd1000, 23'd1000, 24'd500, 24'd100, 23'd10);
      send_query(24'h0, 24'h0, 23'd1000, 23'd1000, 24'd500, 24'd900, 23'd10);
      send_query(24'h0, 24'h0, 23'd1000, 23'd1000, 24'd0, 24'd0, 23'd5);
      send_query(24'h0, 24'h0, 23'd100, 23'd100, -24'sd30, 24'd50, 23'd40);
      send_query(24'h0, 24'h0, 23'd100, 23'd100, 24'd130, 24'd140, 23'd50);
      send_query(24'h0, 24'h0, 23'd100, 23'd100, 24'd130, 24'd140, 23'd49);
      send_query(24'h0, 24'h0, 23'd100, 23'd100, -24'sd3, -24'sd4, 23'd5);
      send_query(24'h800000, 24'h800000, 23'h7FFFFF, 23'h7FFFFF, 24'h0, 24'h0, 23'h7FFFFF);
      send_query(24'h800000, 24'h800000, 23'h7FFFFF, 23'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
                 23'h7FFFFF);
      send_query(24'h7FFFFF, 24'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF, 24'h800000, 24'h800000,
                 23'h7FFFFF);
      send_query(24'h7FFFFF, 24'h800000, 23'h0, 23'h7FFFFF, 24'h800000, 24'h7FFFFF, 23'h0);
      send_query(24'h0, 24'h0, 23'd0, 23'd0, 24'd1, 24'd0, 23'd1);
      send_query(24'h0, 24'h0, 23'd0, 23'd0, 24'd0, -24'sd1, 23'd1);
      send_query(24'h0, 24'h0, 23'h7FFFFF, 23'h7FFFFF, 24'h400000, 24'h400000, 23'h7FFFFF);
   endtask

   task automatic test_random(int count);
      logic [23:0] bl, bt, cxv, cyv;
      logic [22:0] bw, bh, rad;
      repeat (count) begin
         bl = rand_coord(); bt = rand_coord();
         bw = rand_ext(); bh = rand_ext(); rad = rand_ext();
         if ($urandom_range(2) == 0) begin
            cxv = rand_coord(); cyv = rand_coord();
         end else begin
            cxv = bl + 24'($signed($urandom_range(2 * bw + 200)) - 100);
            cyv = bt + 24'($signed($urandom_range(2 * bh + 200)) - 100);
         end
         send_query(bl, bt, bw, bh, cxv, cyv, rad);
      end
   endtask

   initial begin
      req_if.valid = 1'b0;
      req_if.box_left = '0;
      req_if.box_top = '0;
      req_if.box_width = '0;
      req_if.box_height = '0;
      req_if.center_x = '0;
      req_if.center_y = '0;
      req_if.circle_radius = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 33; recv_idle_pct = 60;
      test_directed();
      wait_drained();
      test_random(530);
      wait_drained();
      send_idle_pct = 60; recv_idle_pct = 33;
      test_random(530);
      send_idle_pct = 0; recv_idle_pct = 0;
      test_random(530);
      wait_drained();
      repeat (NFB + 40) @(posedge clock);
      $display("covered %0d queries, %0d hits, %0d with the center on or in the box",
               query_count, hit_count, inside_count);
      $display("checked %0d results, %0d mismatches", result_count, mismatch_count);
      if (mismatch_count == 0 && expected_contacts.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
